>>> hdl/slsi_pkg.sv
// slsi_pkg: shared types and constants for the sorted list insert/remove block
// no dependencies; imported by slsi_cell, sorted_list_insert_remove and the test bench

package slsi_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef struct packed {
        logic   compare;
        logic   insert;
        logic   remove;
        t_value key;
    } t_cell_cmd;

endpackage

>>> hdl/slsi_cell.sv
// slsi_cell: one slot of the sorted list, holds one entry and its compare flags
// depends on slsi_pkg; instantiated in a row by sorted_list_insert_remove

module slsi_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                  i_clk,
    input  slsi_pkg::t_cell_cmd   i_cmd,
    input  logic [CNT_W-1:0]      i_count,
    input  logic                  i_lt_prev,
    input  slsi_pkg::t_value      i_entry_prev,
    input  slsi_pkg::t_value      i_entry_next,
    output slsi_pkg::t_value      o_entry,
    output logic                  o_lt,
    output logic                  o_hit
);
    import slsi_pkg::*;

    t_value r_entry;
    t_value n_entry;
    logic   r_lt;
    logic   r_eq;
    logic   occupied;

    assign occupied = (CNT_W'(IDX) < i_count);

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.insert && !r_lt) begin
            n_entry = i_lt_prev ? i_cmd.key : i_entry_prev;
        end else if (i_cmd.remove && !r_lt) begin
            n_entry = i_entry_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_cmd.compare) begin
            r_lt <= occupied && (r_entry < i_cmd.key);
            r_eq <= occupied && (r_entry == i_cmd.key);
        end
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    // first entry not smaller than the key is equal to it
    assign o_hit   = r_eq && i_lt_prev;

endmodule

>>> hdl/sorted_list_insert_remove.sv
// sorted_list_insert_remove: ascending table of signed values in a row of cells
// each item runs the compare cycle (all cells at once) and then the shift cycle;
// no input beat is taken until the shift commits, which stalls while a result
// still waits in the output register; a new beat is still taken while it waits
// reset (synchronous, active low) empties the table at once; no clearing pass
// depends on slsi_pkg and slsi_cell

module sorted_list_insert_remove #(
    parameter int CAPACITY = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_action,
    input  slsi_pkg::t_value                  i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_ok,
    output logic [slsi_pkg::COUNT_W-1:0]      o_count,
    output logic                              o_is_empty
);
    import slsi_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_COMMIT = 1'b1;

    logic             r_state;
    logic             n_state;
    logic             r_action;
    t_value           r_key;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             r_ok;
    logic [CNT_W-1:0] r_out_count;

    t_cell_cmd        cmd;
    logic             in_beat;
    logic             commit;
    logic             ins_ok;
    logic             rem_ok;
    logic             ok;
    logic [CAPACITY-1:0] lt;
    logic [CAPACITY-1:0] hit;
    t_value           entry [CAPACITY];
    logic [CNT_W+COUNT_W-1:0] count_wide;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_beat    = i_in_valid && o_in_ready;
    assign commit     = (r_state == S_COMMIT) && (!r_out_valid || i_out_ready);

    assign ins_ok = (r_count != CNT_W'(CAPACITY));
    assign rem_ok = |hit;
    assign ok     = (r_action == ACT_INSERT) ? ins_ok : rem_ok;

    always_comb begin
        cmd.compare = in_beat;
        cmd.insert  = commit && (r_action == ACT_INSERT) && ins_ok;
        cmd.remove  = commit && (r_action == ACT_REMOVE) && rem_ok;
        cmd.key     = in_beat ? i_value : r_key;
    end

    always_comb begin
        n_count = r_count;
        if (cmd.insert) begin
            n_count = r_count + 1'b1;
        end else if (cmd.remove) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_action <= i_action;
            r_key    <= i_value;
        end
        if (commit) begin
            r_ok        <= ok;
            r_out_count <= n_count;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic   lt_prev;
            t_value entry_prev;
            t_value entry_next;

            if (gi == 0) begin : g_first
                assign lt_prev    = 1'b1;
                assign entry_prev = '0;
            end else begin : g_mid
                assign lt_prev    = lt[gi-1];
                assign entry_prev = entry[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign entry_next = '0;
            end else begin : g_inner
                assign entry_next = entry[gi+1];
            end

            slsi_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_cmd        (cmd),
                .i_count      (r_count),
                .i_lt_prev    (lt_prev),
                .i_entry_prev (entry_prev),
                .i_entry_next (entry_next),
                .o_entry      (entry[gi]),
                .o_lt         (lt[gi]),
                .o_hit        (hit[gi])
            );
        end
    endgenerate

    assign count_wide  = {{COUNT_W{1'b0}}, r_out_count};
    assign o_out_valid = r_out_valid;
    assign o_ok        = r_ok;
    assign o_count     = count_wide[COUNT_W-1:0];
    assign o_is_empty  = (r_out_count == '0);

endmodule

>>> test/slsi_list_checker.sv
`timescale 1ns / 100ps
// slsi_list_checker: watches both channels of sorted_list_insert_remove, keeps a shadow
// of the sorted table, predicts each result beat and compares it; depends on slsi_pkg

module slsi_list_checker #(
    parameter int CAPACITY = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_action,
    input  slsi_pkg::t_value             i_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic                         i_ok,
    input  logic [slsi_pkg::COUNT_W-1:0] i_count,
    input  logic                         i_is_empty,
    output int                           o_fail_count,
    output int                           o_pending
);

    import slsi_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
    } t_list_result;

    t_value       shadow_list [CAPACITY];
    int           shadow_len;
    t_list_result expected_results [$];

    // shadow table update for one operation, returns the status it implies
    function automatic t_list_result apply_list_op(input logic act, input t_value val);
        t_list_result res;
        int           pos;
        res.ok = 1'b0;
        pos = 0;
        while (pos < shadow_len && shadow_list[pos] < val) pos++;
        if (act == ACT_INSERT) begin
            if (shadow_len < CAPACITY) begin
                for (int j = shadow_len; j > pos; j--) shadow_list[j] = shadow_list[j-1];
                shadow_list[pos] = val;
                shadow_len++;
                res.ok = 1'b1;
            end
        end else begin
            if (shadow_len > 0 && pos < shadow_len && shadow_list[pos] == val) begin
                for (int j = pos; j + 1 < shadow_len; j++) shadow_list[j] = shadow_list[j+1];
                shadow_len--;
                res.ok = 1'b1;
            end
        end
        res.count    = COUNT_W'(shadow_len);
        res.is_empty = (shadow_len == 0);
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        shadow_len   = 0;
    end

    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result exp_res;
        if (!i_rst_n) begin
            shadow_len = 0;
            expected_results.delete();
        end else begin
            // result beat first: it always belongs to an earlier input beat
            if (i_out_valid && i_out_ready) begin
                got = '{ok: i_ok, count: i_count, is_empty: i_is_empty};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat: ok=%0b count=%0d empty=%0b",
                             $time, got.ok, got.count, got.is_empty);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got !== exp_res) begin
                        $display("%0t: expected %0b/%0d/%0b actual %0b/%0d/%0b (ok/count/empty)",
                                 $time, exp_res.ok, exp_res.count, exp_res.is_empty,
                                 got.ok, got.count, got.is_empty);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(apply_list_op(i_action, i_value));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> test/tb_sorted_list_insert_remove.sv
`timescale 1ns / 100ps
// tb_sorted_list_insert_remove: stimulus and verdict for sorted_list_insert_remove
// depends on slsi_pkg, the block itself and slsi_list_checker

module tb_sorted_list_insert_remove;

    import slsi_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 630;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_action;
    t_value             i_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_ok;
    logic [COUNT_W-1:0] o_count;
    logic               o_is_empty;

    int fail_count;
    int pending;
    int send_idle;
    int recv_idle;

    sorted_list_insert_remove #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_action),
        .i_value    (i_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_ok       (o_ok),
        .o_count    (o_count),
        .o_is_empty (o_is_empty)
    );

    slsi_list_checker #(
        .CAPACITY(CAPACITY)
    ) u_list_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_value     (i_value),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_ok        (o_ok),
        .i_count     (o_count),
        .i_is_empty  (o_is_empty),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    initial begin
        #2ms;
        $display("status: fail");
        $finish;
    end

    // small values collide often so removes hit, the rest cover all bits
    function automatic t_value pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return t_value'($signed($urandom_range(0, 15)) - 8);
        if (sel == 6) begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return t_value'($urandom);
    endfunction

    // called at a clock edge; returns at the edge where the beat is taken
    task automatic send_beat(input logic act, input t_value val);
        if ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_value    <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    initial begin
        int phase_len;
        int ins_bias;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_action   = ACT_INSERT;
        i_value    = '0;
        i_out_ready = 1'b0;
        send_idle  = 27;
        recv_idle  = 76;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, extremes, duplicates, absent value, full table
        send_beat(ACT_REMOVE, 32'sd7);
        send_beat(ACT_INSERT, 32'sh7fff_ffff);
        send_beat(ACT_INSERT, 32'sh8000_0000);
        send_beat(ACT_INSERT, 32'sd0);
        send_beat(ACT_INSERT, -32'sd1);
        send_beat(ACT_INSERT, 32'sd0);
        send_beat(ACT_REMOVE, 32'sd5);
        send_beat(ACT_REMOVE, 32'sd0);
        repeat (12) send_beat(ACT_INSERT, t_value'($urandom));
        send_beat(ACT_INSERT, 32'sd3);
        send_beat(ACT_REMOVE, 32'sh8000_0000);
        send_beat(ACT_REMOVE, 32'sh7fff_ffff);

        // blocks of 40 beats lean toward insert or remove so the table
        // swings between full and empty
        phase_len = RANDOM_ITEMS / 3;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == phase_len) begin
                send_idle = 76;
                recv_idle = 27;
            end else if (i == 2 * phase_len) begin
                send_idle = 0;
                recv_idle = 0;
            end
            ins_bias = ((i / 40) % 2 == 0) ? 70 : 30;
            send_beat(($urandom_range(0, 99) < ins_bias) ? ACT_INSERT : ACT_REMOVE,
                      pick_value());
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
